FILE: rtl/core/fcft_pkg.sv
// ----------------------------------------------------------------------------
// fcft_pkg
// Shared types and constants for the frame classify / filter / tag block.
// ----------------------------------------------------------------------------
package fcft_pkg;

  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 32;
  localparam int HOLD_BYTES = 24;
  localparam int HOLD_AW    = $clog2(HOLD_BYTES);
  localparam int POS_W      = $clog2(HOLD_BYTES + 1);
  localparam int STAMP_W    = 64;
  localparam int STAMP_BYTES = STAMP_W / 8;
  localparam int TAG_BYTES  = STAMP_BYTES + 2;
  localparam int TAG_CW     = $clog2(TAG_BYTES);
  localparam int CFG_IW     = 8;

  localparam logic [HOLD_AW-1:0] IDX_TYPE_HI = HOLD_AW'(12);
  localparam logic [HOLD_AW-1:0] IDX_TYPE_LO = HOLD_AW'(13);
  localparam logic [HOLD_AW-1:0] IDX_PROTO   = HOLD_AW'(23);
  localparam logic [HOLD_AW-1:0] IDX_LAST    = HOLD_AW'(HOLD_BYTES - 1);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [7:0]  IP_TCP   = 8'd6;
  localparam logic [7:0]  IP_UDP   = 8'd17;

  localparam logic [7:0] CODE_NONE  = 8'h00;
  localparam logic [7:0] CODE_TCP   = 8'h01;
  localparam logic [7:0] CODE_UDP   = 8'h02;
  localparam logic [7:0] CODE_ARP   = 8'h03;
  localparam logic [7:0] CODE_OTHER = 8'h04;
  localparam logic [7:0] CODE_HI    = 8'h00;

  localparam logic [CFG_IW-1:0] REG_LOG_ARP   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_LOG_TCP   = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_LOG_UDP   = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_LOG_OTHER = CFG_IW'(3);

  typedef enum logic [1:0] {
    CLS_ARP   = 2'd0,
    CLS_TCP   = 2'd1,
    CLS_UDP   = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  typedef logic [TOTAL_W-1:0] total_t;

  // decision handed from the classifier to the emitter
  typedef struct packed {
    logic               start;
    logic               pass;
    logic               last;
    logic [HOLD_AW-1:0] end_idx;
    logic [7:0]         code;
  } dec_t;

endpackage

FILE: rtl/core/fcft_ram.sv
// ----------------------------------------------------------------------------
// fcft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcft_ram #(
  parameter int W = 8,
  parameter int D = 24
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/fcft_classify.sv
// ----------------------------------------------------------------------------
// fcft_classify
// Frame position tracking, EtherType/protocol decision, class enables and
// class counters. Drives the head store write port.
// ----------------------------------------------------------------------------
module fcft_classify (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  input  logic                       cfg_wr,
  input  logic [fcft_pkg::CFG_IW-1:0] cfg_index,
  input  logic                       cfg_data,
  output fcft_pkg::dec_t             dec,
  output logic                       wr_en,
  output logic [fcft_pkg::HOLD_AW-1:0] wr_addr,
  output fcft_pkg::total_t           arp_total,
  output fcft_pkg::total_t           tcp_total,
  output fcft_pkg::total_t           udp_total,
  output fcft_pkg::total_t           other_total
);
  import fcft_pkg::*;

  logic [POS_W-1:0]   pos_r;
  logic               decided_r;
  logic               kept_r;
  logic [7:0]         type_hi_r;
  logic [3:0]         en_r;
  logic [COUNT_W-1:0] cnt_r [4];

  logic [HOLD_AW-1:0] p;
  logic [15:0]        tw;
  logic [7:0]         code;
  cls_t               cls;
  logic               hit;
  logic               en;

  always_comb begin
    hit  = acc && !decided_r;
    p    = (pos_r >= POS_W'(HOLD_BYTES)) ? IDX_LAST : pos_r[HOLD_AW-1:0];
    tw   = {type_hi_r, in_byte};
    code = CODE_NONE;
    cls  = CLS_OTHER;
    if (p == IDX_TYPE_LO && tw != ETH_IPV4) begin
      if (tw == ETH_ARP) begin
        code = CODE_ARP;
        cls  = CLS_ARP;
      end else begin
        code = CODE_OTHER;
      end
    end else if (p == IDX_PROTO) begin
      if (in_byte == IP_TCP) begin
        code = CODE_TCP;
        cls  = CLS_TCP;
      end else if (in_byte == IP_UDP) begin
        code = CODE_UDP;
        cls  = CLS_UDP;
      end else begin
        code = CODE_OTHER;
      end
    end
    if (code == CODE_NONE && in_last) begin
      code = CODE_OTHER;
      cls  = CLS_OTHER;
    end
    en = en_r[cls];

    dec.start   = hit && code != CODE_NONE && en;
    dec.pass    = acc && decided_r && kept_r;
    dec.last    = in_last;
    dec.end_idx = p;
    dec.code    = code;
    wr_en       = hit;
    wr_addr     = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      decided_r <= 1'b0;
      kept_r    <= 1'b0;
      type_hi_r <= '0;
      en_r      <= '1;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_LOG_ARP:   en_r[CLS_ARP]   <= cfg_data;
          REG_LOG_TCP:   en_r[CLS_TCP]   <= cfg_data;
          REG_LOG_UDP:   en_r[CLS_UDP]   <= cfg_data;
          REG_LOG_OTHER: en_r[CLS_OTHER] <= cfg_data;
          default: ;
        endcase
      end
      if (dec.start) begin
        cnt_r[cls] <= cnt_r[cls] + COUNT_W'(1);
      end
      if (acc) begin
        if (in_last) begin
          pos_r     <= '0;
          decided_r <= 1'b0;
          kept_r    <= 1'b0;
          type_hi_r <= '0;
        end else if (hit) begin
          pos_r <= POS_W'(p) + POS_W'(1);
          if (p == IDX_TYPE_HI) begin
            type_hi_r <= in_byte;
          end
          if (code != CODE_NONE) begin
            decided_r <= 1'b1;
            kept_r    <= en;
          end
        end else if (pos_r < POS_W'(HOLD_BYTES)) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  assign arp_total   = TOTAL_W'(cnt_r[CLS_ARP]);
  assign tcp_total   = TOTAL_W'(cnt_r[CLS_TCP]);
  assign udp_total   = TOTAL_W'(cnt_r[CLS_UDP]);
  assign other_total = TOTAL_W'(cnt_r[CLS_OTHER]);

endmodule

FILE: rtl/core/fcft_emit.sv
// ----------------------------------------------------------------------------
// fcft_emit
// Tag and replay sequencer: emits the tag, reads the held bytes back from
// the head store through a read stage, passes later bytes and owns the
// output register.
// ----------------------------------------------------------------------------
module fcft_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcft_pkg::dec_t               dec,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  input  logic signed [fcft_pkg::STAMP_W-1:0] in_stamp,
  output logic                         in_stall,
  output logic                         rd_en,
  output logic [fcft_pkg::HOLD_AW-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_last
);
  import fcft_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_REPLAY
  } state_t;

  state_t             state_r,   state_nxt;
  logic [TAG_CW-1:0]  tcnt_r,    tcnt_nxt;
  logic [HOLD_AW-1:0] ridx_r,    ridx_nxt;
  logic [HOLD_AW-1:0] end_r,     end_nxt;
  logic               rep_last_r, rep_last_nxt;
  logic [STAMP_W-1:0] stamp_r,   stamp_nxt;
  logic [7:0]         code_r,    code_nxt;
  logic               rv_r,      rv_nxt;
  logic               rlast_r,   rlast_nxt;
  logic               ov_r,      ov_nxt;
  logic [7:0]         ob_r,      ob_nxt;
  logic               ol_r,      ol_nxt;

  logic o_free;
  logic adv;

  always_comb begin
    o_free       = !ov_r || !out_stall;
    adv          = !rv_r || o_free;
    state_nxt    = state_r;
    tcnt_nxt     = tcnt_r;
    ridx_nxt     = ridx_r;
    end_nxt      = end_r;
    rep_last_nxt = rep_last_r;
    stamp_nxt    = stamp_r;
    code_nxt     = code_r;
    rv_nxt       = rv_r;
    rlast_nxt    = rlast_r;
    ov_nxt       = ov_r;
    ob_nxt       = ob_r;
    ol_nxt       = ol_r;
    rd_en        = 1'b0;
    rd_addr      = ridx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (dec.start) begin
          state_nxt    = ST_TAG;
          tcnt_nxt     = '0;
          stamp_nxt    = in_stamp;
          code_nxt     = dec.code;
          end_nxt      = dec.end_idx;
          rep_last_nxt = dec.last;
        end
      end
      ST_TAG: begin
        if (o_free) begin
          if (tcnt_r == TAG_CW'(TAG_BYTES - 1)) begin
            state_nxt = ST_REPLAY;
            ridx_nxt  = '0;
          end else begin
            tcnt_nxt = tcnt_r + TAG_CW'(1);
          end
        end
      end
      ST_REPLAY: begin
        if (adv) begin
          rd_en     = 1'b1;
          rlast_nxt = rep_last_r && ridx_r == end_r;
          if (ridx_r == end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ridx_nxt = ridx_r + HOLD_AW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (o_free) begin
      ov_nxt = 1'b0;
      if (state_r == ST_TAG) begin
        ov_nxt = 1'b1;
        ol_nxt = 1'b0;
        if (tcnt_r < TAG_CW'(STAMP_BYTES)) begin
          ob_nxt = stamp_r[{tcnt_r[2:0], 3'b000} +: 8];
        end else if (tcnt_r == TAG_CW'(STAMP_BYTES)) begin
          ob_nxt = code_r;
        end else begin
          ob_nxt = CODE_HI;
        end
      end else if (rv_r) begin
        ov_nxt = 1'b1;
        ob_nxt = rd_data;
        ol_nxt = rlast_r;
        rv_nxt = 1'b0;
      end else if (dec.pass) begin
        ov_nxt = 1'b1;
        ob_nxt = in_byte;
        ol_nxt = in_last;
      end
    end
    if (rd_en) begin
      rv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
      tcnt_r  <= '0;
      ridx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
      tcnt_r  <= tcnt_nxt;
      ridx_r  <= ridx_nxt;
    end
    end_r      <= end_nxt;
    rep_last_r <= rep_last_nxt;
    stamp_r    <= stamp_nxt;
    code_r     <= code_nxt;
    rlast_r    <= rlast_nxt;
    ob_r       <= ob_nxt;
    ol_r       <= ol_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE) || rv_r || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

endmodule

FILE: rtl/core/frame_classify_filter_tag_top.sv
// ----------------------------------------------------------------------------
// frame_classify_filter_tag_top
// Ethernet frame classifier: counts and tags enabled ARP/TCP/UDP/other frames.
// A passed byte reaches the output register in the cycle after its transfer.
// Throughput: one byte per cycle unless stalled. An enabled frame's deciding byte starts
// 10 tag bytes, a gap and up to 24 replayed bytes; input is held off until they are out.
// Reset: frame state and counters cleared, all classes enabled; head store not cleared.
// ----------------------------------------------------------------------------
module frame_classify_filter_tag_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  input  logic signed [fcft_pkg::STAMP_W-1:0] in_stamp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output fcft_pkg::total_t              out_arp_total,
  output fcft_pkg::total_t              out_tcp_total,
  output fcft_pkg::total_t              out_udp_total,
  output fcft_pkg::total_t              out_other_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcft_pkg::CFG_IW-1:0]   cfg_index,
  input  logic                          cfg_data
);
  import fcft_pkg::*;

  dec_t               dec;
  logic               acc;
  logic               wr_en;
  logic [HOLD_AW-1:0] wr_addr;
  logic               rd_en;
  logic [HOLD_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;

  fcft_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dec         (dec),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .arp_total   (out_arp_total),
    .tcp_total   (out_tcp_total),
    .udp_total   (out_udp_total),
    .other_total (out_other_total)
  );

  fcft_ram #(
    .W (8),
    .D (HOLD_BYTES)
  ) u_head_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fcft_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .in_stamp  (in_stamp),
    .in_stall  (in_stall),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: tb/sv/frame_classify_filter_tag_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_classify_filter_tag_top_tb
// Self-checking bench for the frame classifier. Frames are sent one byte per
// transfer; a local copy of the classifier predicts the tag, the replayed
// head and the pass-through bytes with their class totals, and every output
// transfer is compared field by field. A short list of hand-built frames is
// followed by random frames under several enable settings and idle patterns.
// ----------------------------------------------------------------------------
module frame_classify_filter_tag_top_tb;
  import fcft_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 4;
  localparam int PHASE_BYTES   = 16;
  localparam int FILL_RAND     = -1;
  localparam logic [CFG_IW-1:0] REG_BAD_LO = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] REG_BAD_HI = {CFG_IW{1'b1}};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    total_t     arp;
    total_t     tcp;
    total_t     udp;
    total_t     other;
  } egress_t;

  typedef struct packed {
    logic [3:0]  en;
    logic [15:0] etype;
    logic [7:0]  proto;
    int          len;
    logic [63:0] stamp;
    int          fill;
    logic [7:0]  code;
  } frame_row_t;

  // en bits follow register indexes: [0] arp, [1] tcp, [2] udp, [3] other
  localparam int ROWS = 13;
  localparam frame_row_t PLAN [ROWS] = '{
    '{4'hF, ETH_ARP,   8'h00,    16, 64'h0123_4567_89AB_CDEF, FILL_RAND, CODE_ARP},
    '{4'hF, ETH_IPV4,  IP_TCP,   24, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00,     CODE_TCP},
    '{4'hF, ETH_IPV4,  IP_UDP,   24, 64'h8000_0000_0000_0000, 8'hFF,     CODE_UDP},
    '{4'hF, ETH_IPV4,  8'h01,    24, 64'hFFFF_FFFF_FFFF_FFFF, FILL_RAND, CODE_OTHER},
    '{4'hF, 16'h86DD,  8'h00,    14, 64'h0000_0000_0000_0000, FILL_RAND, CODE_OTHER},
    '{4'hF, ETH_IPV4,  8'h00,     1, 64'hDEAD_BEEF_0000_0001, FILL_RAND, CODE_OTHER},
    '{4'hF, ETH_ARP,   8'h00,    13, 64'h0000_0000_0000_00FF, FILL_RAND, CODE_OTHER},
    '{4'hF, ETH_IPV4,  IP_TCP,   26, 64'h0F1E_2D3C_4B5A_6978, FILL_RAND, CODE_TCP},
    '{4'h0, ETH_IPV4,  8'h00,     5, 64'h3333_3333_3333_3333, FILL_RAND, CODE_NONE},
    '{4'h5, ETH_ARP,   8'h00,    14, 64'h4444_4444_4444_4444, FILL_RAND, CODE_ARP},
    '{4'h5, ETH_IPV4,  IP_UDP,   24, 64'h6666_6666_6666_6666, FILL_RAND, CODE_UDP},
    '{4'hA, 16'h88CC,  8'h00,    14, 64'h7777_7777_7777_7777, FILL_RAND, CODE_OTHER},
    '{4'hA, ETH_ARP,   8'h00,    14, 64'h8888_8888_8888_8888, FILL_RAND, CODE_NONE}
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte   = 8'h00;
  logic                 in_last   = 1'b0;
  logic signed [STAMP_W-1:0] in_stamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last;
  total_t               out_arp_total;
  total_t               out_tcp_total;
  total_t               out_udp_total;
  total_t               out_other_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic                 cfg_data  = 1'b0;

  // classifier copy
  logic       class_on [4] = '{1'b1, 1'b1, 1'b1, 1'b1};
  total_t     frame_count [4] = '{'0, '0, '0, '0};
  logic [7:0] rx_head [HOLD_BYTES];
  int         rx_pos       = 0;
  logic       rx_decided   = 1'b0;
  logic       rx_keep      = 1'b0;
  logic [15:0] rx_ethertype = '0;
  logic [7:0] typed_code   = CODE_NONE;
  egress_t    egress_due [$];

  logic [3:0] cur_en      = 4'hF;
  int         snd_pct     = 0;
  int         rcv_pct     = 0;
  int         mismatches  = 0;
  int         bytes_sent  = 0;
  int         beats_seen  = 0;
  int         cfg_writes  = 0;
  int         cycle_count = 0;
  int         frames_seen [4] = '{0, 0, 0, 0};

  frame_classify_filter_tag_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .in_stamp        (in_stamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_arp_total   (out_arp_total),
    .out_tcp_total   (out_tcp_total),
    .out_udp_total   (out_udp_total),
    .out_other_total (out_other_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic void queue_egress(input logic [7:0] data, input logic last);
    egress_due.push_back('{data: data, last: last, arp: frame_count[CLS_ARP],
                           tcp: frame_count[CLS_TCP], udp: frame_count[CLS_UDP],
                           other: frame_count[CLS_OTHER]});
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic last,
                                        input logic [63:0] stamp);
    logic [7:0] code;
    int p;
    cls_t cls;
    if (!rx_decided) begin
      p = (rx_pos >= HOLD_BYTES) ? HOLD_BYTES - 1 : rx_pos;
      rx_head[p] = b;
      if (p == 12) rx_ethertype = {b, 8'h00};
      if (p == 13) rx_ethertype = {rx_ethertype[15:8], b};
      code = CODE_NONE;
      if (p == 13 && rx_ethertype != ETH_IPV4) begin
        code = (rx_ethertype == ETH_ARP) ? CODE_ARP : CODE_OTHER;
      end else if (p == 23) begin
        code = (b == IP_TCP) ? CODE_TCP : (b == IP_UDP) ? CODE_UDP : CODE_OTHER;
      end
      if (code == CODE_NONE && last) code = CODE_OTHER;
      rx_pos = p + 1;
      if (code != CODE_NONE) begin
        rx_decided = 1'b1;
        case (code)
          CODE_ARP: cls = CLS_ARP;
          CODE_TCP: cls = CLS_TCP;
          CODE_UDP: cls = CLS_UDP;
          default:  cls = CLS_OTHER;
        endcase
        frames_seen[cls]++;
        rx_keep = class_on[cls];
        if (rx_keep) begin
          frame_count[cls] = frame_count[cls] + 1'b1;
          for (int i = 0; i < STAMP_BYTES; i++) queue_egress(stamp[8*i +: 8], 1'b0);
          // hand-typed class code where the frame plan gives one
          queue_egress((typed_code != CODE_NONE) ? typed_code : code, 1'b0);
          queue_egress(CODE_HI, 1'b0);
          for (int i = 0; i <= p; i++) queue_egress(rx_head[i], last && i == p);
        end
      end
    end else begin
      if (rx_pos < HOLD_BYTES) rx_pos++;
      if (rx_keep) queue_egress(b, last);
    end
    if (last) begin
      rx_pos       = 0;
      rx_decided   = 1'b0;
      rx_keep      = 1'b0;
      rx_ethertype = '0;
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    egress_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (egress_due.size() == 0) begin
        $error("out_byte: expected no transfer, got 0x%0h", out_byte);
        mismatches++;
      end else begin
        want = egress_due.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_last", want.last, out_last);
        check_field("out_arp_total", want.arp, out_arp_total);
        check_field("out_tcp_total", want.tcp, out_tcp_total);
        check_field("out_udp_total", want.udp, out_udp_total);
        check_field("out_other_total", want.other, out_other_total);
        beats_seen++;
      end
    end
    out_stall <= ($urandom_range(99) < rcv_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] stamp);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    in_stamp <= stamp;
    do @(posedge clk); while (in_stall);
    classify_byte(b, last, stamp);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] etype, input logic [7:0] proto,
                            input int len, input int fill, input logic [63:0] stamp,
                            input bit fresh_stamp);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 12) b = etype[15:8];
      else if (i == 13) b = etype[7:0];
      else if (i == 23) b = proto;
      else if (fill == FILL_RAND) b = 8'($urandom_range(255));
      else b = 8'(fill);
      if (fresh_stamp) stamp = {$urandom, $urandom};
      send_byte(b, i == len - 1, stamp);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (egress_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOG_ARP:   class_on[CLS_ARP]   = val;
      REG_LOG_TCP:   class_on[CLS_TCP]   = val;
      REG_LOG_UDP:   class_on[CLS_UDP]   = val;
      REG_LOG_OTHER: class_on[CLS_OTHER] = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_enables(input logic [3:0] en);
    drain();
    cfg_write(REG_LOG_ARP, en[0]);
    cfg_write(REG_LOG_TCP, en[1]);
    cfg_write(REG_LOG_UDP, en[2]);
    cfg_write(REG_LOG_OTHER, en[3]);
    // out-of-range indexes must not touch any enable
    cfg_write(REG_BAD_HI, ~en[0]);
    cfg_write(CFG_IW'($urandom_range(REG_BAD_HI, REG_BAD_LO)), ~en[3]);
    cur_en = en;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d transfers pending", cycle_count,
             egress_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [3:0]  en;
    logic [15:0] etype;
    logic [7:0]  proto;
    int          budget;
    int          roll;
    int          len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      if (PLAN[r].en != cur_en) apply_enables(PLAN[r].en);
      typed_code = PLAN[r].code;
      send_frame(PLAN[r].etype, PLAN[r].proto, PLAN[r].len, PLAN[r].fill,
                 PLAN[r].stamp, 1'b0);
    end
    typed_code = CODE_NONE;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 65; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 65; end
        default: begin snd_pct = 22; rcv_pct = 22; end
      endcase
      if (ph == 1 || ph == PHASES - 1) en = 4'($urandom_range(15));
      else en = 4'hF;
      apply_enables(en);
      budget = bytes_sent + PHASE_BYTES;
      while (bytes_sent < budget) begin
        roll  = $urandom_range(99);
        proto = 8'($urandom_range(255));
        if (roll < 25) begin
          etype = ETH_ARP;
        end else if (roll < 80) begin
          etype = ETH_IPV4;
          if (roll < 50) proto = IP_TCP;
          else if (roll < 72) proto = IP_UDP;
        end else begin
          etype = 16'($urandom_range(16'hFFFF));
        end
        roll = $urandom_range(99);
        if (roll < 15) len = $urandom_range(23, 1);
        else if (roll < 88) len = $urandom_range(34, 14);
        else len = $urandom_range(80, 35);
        send_frame(etype, proto, len, FILL_RAND, '0, 1'b1);
      end
    end
    drain();

    $display("sent %0d bytes: %0d ARP, %0d TCP, %0d UDP, %0d other frames",
             bytes_sent, frames_seen[CLS_ARP], frames_seen[CLS_TCP],
             frames_seen[CLS_UDP], frames_seen[CLS_OTHER]);
    $display("checked %0d output transfers across %0d enable writes and four idle patterns",
             beats_seen, cfg_writes);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
